// ===== rtl/peak_to_peak_gain_control_assert.svh =====
// Assertion macros shared by the peak-to-peak gain control RTL.
// Each macro expects the including module to have i_clk and i_rst_n.
`ifndef PEAK_TO_PEAK_GAIN_CONTROL_ASSERT_SVH
`define PEAK_TO_PEAK_GAIN_CONTROL_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PPGC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPGC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ppgc_pkg.sv =====
// Package for the peak-to-peak gain control block: widths, reset values,
// state and phase types and the divider status struct. No dependencies.
package ppgc_pkg;

    // Depth of the gain history.
    localparam int WINDOW = 10;

    localparam int SAMPLE_W   = 11;
    localparam int GAIN_W     = 7;
    localparam int SPAN_W     = 11;
    localparam int TIMER_W    = 16;
    localparam int PULSE_W    = 9;
    localparam int STEPS_W    = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    localparam int GAIN_MAXVAL = (1 << GAIN_W) - 1;
    localparam int HIST_CNT_W  = $clog2(WINDOW + 1);
    localparam int HIST_SUM_W  = $clog2(WINDOW * GAIN_MAXVAL + 1);

    // Shared divider width and its iteration counter.
    localparam int DIV_W     = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic signed [SAMPLE_W-1:0] EXT_HIGH_RST = -11'sd1023;
    localparam logic signed [SAMPLE_W-1:0] EXT_LOW_RST  = 11'sd1023;

    localparam logic [CFG_DATA_W-1:0] GAIN_NUM_RST = 16'd400;
    localparam logic [TIMER_W-1:0]    SETTLE_RST   = 16'd2000;
    localparam logic [TIMER_W-1:0]    HOLD_RST     = 16'd200;
    localparam logic [GAIN_W-1:0]     GAIN_MAX_RST = 7'd100;
    localparam logic [GAIN_W-1:0]     GAIN_MIN_RST = 7'd1;
    localparam logic [STEPS_W-1:0]    PULSE_HI_RST = 8'd4;
    localparam logic [STEPS_W-1:0]    PULSE_LO_RST = 8'd4;
    localparam logic [STEPS_W-1:0]    STARTUP_RST  = 8'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_NUM  = 3'd0,
        CFG_SETTLE    = 3'd1,
        CFG_HOLD      = 3'd2,
        CFG_GAIN_MAX  = 3'd3,
        CFG_GAIN_MIN  = 3'd4,
        CFG_PULSE_HI  = 3'd5,
        CFG_PULSE_LO  = 3'd6,
        CFG_STARTUP   = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_STARTUP = 2'd0,
        PH_IDLE    = 2'd1,
        PH_STEP    = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_SPAN,
        S_DIV_GAIN,
        S_HIST,
        S_DIV_MEAN,
        S_SET,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== rtl/peak_to_peak_gain_control.sv =====
// Top level of the peak-to-peak automatic gain control.
// Depends on ppgc_pkg, ppgc_div and peak_to_peak_gain_control_assert.svh.
//
//   Channel  Direction  Handshake                  Contents
//   s        in         i_s_tvalid / o_s_tready     one timer tick: IR and red sample
//   m        out        o_m_tvalid / i_m_tready     one result item per tick
//   cfg      in         i_cfg_we                    register write, no read-back
//
// A tick that runs no evaluation passes from the tick state straight to the emit
// state, which loads the result register. An evaluating tick passes through the
// span state, the gain division, the history state, the mean division and the
// set-up state before the emit state; each division holds the sequencer until the
// divider raises its done flag after the last quotient bit. A zero span skips the
// gain division.
// Only one item is in work at a time; the next one is accepted as soon as the
// sequencer is back in its idle state, even while the last result is unclaimed.
// A stalled output holds the sequencer in its emit state until the item is taken.
// Reset is synchronous and active low; after it the block starts with its
// start-up down pulses, counted one tick at a time.
`include "peak_to_peak_gain_control_assert.svh"

module peak_to_peak_gain_control
    import ppgc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input item, from bit 0: ir_sample[10:0], red_sample[21:11], zero pad.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // Result item, from bit 0: inc_pin, updown_pin, gain_now[8:2],
    // gain_target[15:9], span[26:16], evaluated[27], busy_res[28], zero pad.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_gain_num;
    logic [TIMER_W-1:0]    r_settle_ticks;
    logic [TIMER_W-1:0]    r_hold_ticks;
    logic [GAIN_W-1:0]     r_gain_max;
    logic [GAIN_W-1:0]     r_gain_min;
    logic [STEPS_W-1:0]    r_pulse_hi;
    logic [STEPS_W-1:0]    r_pulse_lo;
    logic [STEPS_W-1:0]    r_startup_steps;

    // Sequencer.
    t_state r_state;
    t_state n_state;

    // Captured samples of the current tick.
    logic signed [SAMPLE_W-1:0] r_ir;
    logic signed [SAMPLE_W-1:0] r_red;

    // Tracking and control state.
    logic signed [SAMPLE_W-1:0] r_ir_hi;
    logic signed [SAMPLE_W-1:0] r_ir_lo;
    logic signed [SAMPLE_W-1:0] r_red_hi;
    logic signed [SAMPLE_W-1:0] r_red_lo;
    logic [TIMER_W-1:0]         r_settle;
    logic [TIMER_W-1:0]         r_hold;
    logic [GAIN_W-1:0]          r_hist [WINDOW];
    logic [HIST_CNT_W-1:0]      r_hist_cnt;
    logic [HIST_SUM_W-1:0]      r_hist_sum;
    logic [GAIN_W-1:0]          r_gain;
    logic [GAIN_W-1:0]          r_target;
    t_phase                     r_phase;
    logic [PULSE_W-1:0]         r_pulse_t;
    logic [STEPS_W-1:0]         r_steps;
    logic                       r_step_up;
    logic [SPAN_W-1:0]          r_span;
    logic                       r_inc;
    logic                       r_eval;
    logic [DIV_W-1:0]           r_quot;

    // Result register.
    logic                  r_m_tvalid;
    logic [OUT_DATA_W-1:0] r_m_tdata;

    // Handshake and sequencer outputs.
    logic in_acc;
    logic out_free;
    logic ld_out;
    logic div_start;

    // Divider connection.
    t_div_stat        div_stat;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_quo;

    // Per-tick update, evaluated in S_TICK.
    logic [TIMER_W-1:0]         tk_settle;
    logic [TIMER_W-1:0]         tk_hold;
    t_phase                     tk_phase;
    logic [STEPS_W-1:0]         tk_steps;
    logic [GAIN_W-1:0]          tk_gain;
    logic                       tk_step_up;
    logic [PULSE_W-1:0]         tk_pulse_t;
    logic                       tk_inc;
    logic                       tk_eval;
    logic signed [SAMPLE_W-1:0] tk_ir_hi;
    logic signed [SAMPLE_W-1:0] tk_ir_lo;
    logic signed [SAMPLE_W-1:0] tk_red_hi;
    logic signed [SAMPLE_W-1:0] tk_red_lo;

    // Pulse timing.
    logic               pl_level;
    logic [PULSE_W-1:0] pl_inc_t;
    logic               pl_done;

    // Span, clamp and history arithmetic.
    logic signed [SAMPLE_W:0] sp_red;
    logic signed [SAMPLE_W:0] sp_ir;
    logic signed [SAMPLE_W:0] sp_max;
    logic [SPAN_W-1:0]        sp_span;
    logic                     sp_zero;
    logic [DIV_W-1:0]         cl_upper;
    logic [DIV_W-1:0]         cl_both;
    logic [GAIN_W-1:0]        cl_gain;
    logic [HIST_CNT_W-1:0]    hs_cnt;
    logic [HIST_SUM_W-1:0]    hs_sum;

    assign in_acc   = i_s_tvalid && o_s_tready;
    assign out_free = !r_m_tvalid || i_m_tready;

    // ------------------------------------------------------------------
    // Configuration writes.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_num      <= GAIN_NUM_RST;
            r_settle_ticks  <= SETTLE_RST;
            r_hold_ticks    <= HOLD_RST;
            r_gain_max      <= GAIN_MAX_RST;
            r_gain_min      <= GAIN_MIN_RST;
            r_pulse_hi      <= PULSE_HI_RST;
            r_pulse_lo      <= PULSE_LO_RST;
            r_startup_steps <= STARTUP_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_NUM: r_gain_num      <= i_cfg_wdata;
                CFG_SETTLE:   r_settle_ticks  <= i_cfg_wdata;
                CFG_HOLD:     r_hold_ticks    <= i_cfg_wdata;
                CFG_GAIN_MAX: r_gain_max      <= i_cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_MIN: r_gain_min      <= i_cfg_wdata[GAIN_W-1:0];
                CFG_PULSE_HI: r_pulse_hi      <= i_cfg_wdata[STEPS_W-1:0];
                CFG_PULSE_LO: r_pulse_lo      <= i_cfg_wdata[STEPS_W-1:0];
                CFG_STARTUP:  r_startup_steps <= i_cfg_wdata[STEPS_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pulse timer: one tick of the current potentiometer pulse. The pin is
    // high for the first pulse_high ticks and low for the remainder.
    // ------------------------------------------------------------------
    always_comb begin
        pl_level = (r_pulse_t < {1'b0, r_pulse_hi});
        pl_inc_t = r_pulse_t + 1'b1;
        pl_done  = (pl_inc_t >= ({1'b0, r_pulse_hi} + {1'b0, r_pulse_lo}));
    end

    // ------------------------------------------------------------------
    // Tick processing. Both timers saturate; the start-up phase ends at the
    // first tick whose completed-pulse count has reached the start-up length,
    // and that tick is then handled as an idle one.
    // ------------------------------------------------------------------
    always_comb begin
        tk_settle  = (r_settle != '1) ? r_settle + 1'b1 : r_settle;
        tk_hold    = (r_hold != '1) ? r_hold + 1'b1 : r_hold;
        tk_phase   = r_phase;
        tk_steps   = r_steps;
        tk_gain    = r_gain;
        tk_step_up = r_step_up;
        tk_pulse_t = r_pulse_t;
        tk_inc     = 1'b0;
        tk_eval    = 1'b0;
        tk_ir_hi   = r_ir_hi;
        tk_ir_lo   = r_ir_lo;
        tk_red_hi  = r_red_hi;
        tk_red_lo  = r_red_lo;

        if (r_phase == PH_STARTUP && r_steps >= r_startup_steps) begin
            tk_phase = PH_IDLE;
            tk_steps = '0;
            tk_gain  = GAIN_W'(1);
        end

        priority if (tk_phase == PH_STARTUP) begin
            tk_step_up = 1'b0;
            tk_inc     = pl_level;
            if (r_pulse_t == '0) begin
                tk_settle = '0;
            end
            tk_pulse_t = pl_done ? '0 : pl_inc_t;
            if (pl_done) begin
                tk_steps = tk_steps + 1'b1;
            end
        end else if (tk_phase == PH_STEP) begin
            tk_inc = pl_level;
            if (r_pulse_t == '0) begin
                tk_settle = '0;
            end
            tk_pulse_t = pl_done ? '0 : pl_inc_t;
            if (pl_done) begin
                if (r_step_up) begin
                    if (tk_gain != GAIN_W'(GAIN_MAXVAL)) begin
                        tk_gain = tk_gain + 1'b1;
                    end
                end else if (tk_gain != '0) begin
                    tk_gain = tk_gain - 1'b1;
                end
                if (tk_steps != '0) begin
                    tk_steps = tk_steps - 1'b1;
                end
                if (tk_steps == '0) begin
                    tk_phase = PH_IDLE;
                end
            end
        end else if (tk_settle > r_settle_ticks) begin
            // Every new extreme restarts the hold timer.
            if (r_ir < r_ir_lo) begin
                tk_ir_lo = r_ir;
                tk_hold  = '0;
            end
            if (r_red < r_red_lo) begin
                tk_red_lo = r_red;
                tk_hold   = '0;
            end
            if (r_ir > r_ir_hi) begin
                tk_ir_hi = r_ir;
                tk_hold  = '0;
            end
            if (r_red > r_red_hi) begin
                tk_red_hi = r_red;
                tk_hold   = '0;
            end
            tk_eval = (tk_hold >= r_hold_ticks);
        end
    end

    // ------------------------------------------------------------------
    // Span of the larger channel swing, a negative swing counts as zero.
    // ------------------------------------------------------------------
    always_comb begin
        sp_red  = {r_red_hi[SAMPLE_W-1], r_red_hi} - {r_red_lo[SAMPLE_W-1], r_red_lo};
        sp_ir   = {r_ir_hi[SAMPLE_W-1], r_ir_hi} - {r_ir_lo[SAMPLE_W-1], r_ir_lo};
        sp_max  = (sp_red > sp_ir) ? sp_red : sp_ir;
        sp_span = sp_max[SAMPLE_W] ? '0 : sp_max[SPAN_W-1:0];
        sp_zero = (sp_span == '0);
    end

    // ------------------------------------------------------------------
    // Clamp of the quotient (upper bound first, the lower bound wins) and the
    // running history sum after pushing the new gain.
    // ------------------------------------------------------------------
    always_comb begin
        cl_upper = (r_quot >= DIV_W'(r_gain_max)) ? DIV_W'(r_gain_max) : r_quot;
        cl_both  = (cl_upper <= DIV_W'(r_gain_min)) ? DIV_W'(r_gain_min) : cl_upper;
        cl_gain  = cl_both[GAIN_W-1:0];
        hs_cnt   = (r_hist_cnt < HIST_CNT_W'(WINDOW)) ? r_hist_cnt + 1'b1 : r_hist_cnt;
        hs_sum   = r_hist_sum - HIST_SUM_W'(r_hist[0]) + HIST_SUM_W'(cl_gain);
    end

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_s_tvalid) n_state = S_TICK;
            S_TICK:     n_state = tk_eval ? S_SPAN : S_EMIT;
            S_SPAN:     n_state = sp_zero ? S_HIST : S_DIV_GAIN;
            S_DIV_GAIN: if (div_stat.done) n_state = S_HIST;
            S_HIST:     n_state = S_DIV_MEAN;
            S_DIV_MEAN: if (div_stat.done) n_state = S_SET;
            S_SET:      n_state = S_EMIT;
            S_EMIT:     if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs. The divider is loaded with the gain division in
    // S_SPAN and with the mean division in S_HIST.
    // ------------------------------------------------------------------
    always_comb begin
        o_s_tready   = 1'b0;
        div_start    = 1'b0;
        ld_out       = 1'b0;
        div_dividend = r_gain_num;
        div_divisor  = DIV_W'(sp_span);
        unique case (r_state)
            S_IDLE: o_s_tready = 1'b1;
            S_SPAN: div_start  = !sp_zero;
            S_HIST: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(hs_sum);
                div_divisor  = DIV_W'(hs_cnt);
            end
            S_EMIT: ld_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    ppgc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ir  <= $signed(i_s_tdata[SAMPLE_W-1:0]);
            r_red <= $signed(i_s_tdata[2*SAMPLE_W-1:SAMPLE_W]);
        end
    end

    // ------------------------------------------------------------------
    // Gain control state.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ir_hi    <= EXT_HIGH_RST;
            r_ir_lo    <= EXT_LOW_RST;
            r_red_hi   <= EXT_HIGH_RST;
            r_red_lo   <= EXT_LOW_RST;
            r_settle   <= '0;
            r_hold     <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                r_hist[i] <= '0;
            end
            r_hist_cnt <= '0;
            r_hist_sum <= '0;
            r_gain     <= GAIN_W'(1);
            r_target   <= '0;
            r_phase    <= PH_STARTUP;
            r_pulse_t  <= '0;
            r_steps    <= '0;
            r_step_up  <= 1'b0;
            r_span     <= '0;
            r_inc      <= 1'b0;
            r_eval     <= 1'b0;
        end else begin
            unique case (r_state)
                S_TICK: begin
                    r_settle  <= tk_settle;
                    r_hold    <= tk_hold;
                    r_phase   <= tk_phase;
                    r_steps   <= tk_steps;
                    r_gain    <= tk_gain;
                    r_step_up <= tk_step_up;
                    r_pulse_t <= tk_pulse_t;
                    r_ir_hi   <= tk_ir_hi;
                    r_ir_lo   <= tk_ir_lo;
                    r_red_hi  <= tk_red_hi;
                    r_red_lo  <= tk_red_lo;
                    r_inc     <= tk_inc;
                    r_eval    <= tk_eval;
                end
                S_SPAN: begin
                    // The extremes restart once they have been measured.
                    r_span   <= sp_span;
                    r_ir_hi  <= EXT_HIGH_RST;
                    r_ir_lo  <= EXT_LOW_RST;
                    r_red_hi <= EXT_HIGH_RST;
                    r_red_lo <= EXT_LOW_RST;
                end
                S_HIST: begin
                    for (int i = 0; i < WINDOW - 1; i++) begin
                        r_hist[i] <= r_hist[i+1];
                    end
                    r_hist[WINDOW-1] <= cl_gain;
                    r_hist_cnt       <= hs_cnt;
                    r_hist_sum       <= hs_sum;
                end
                S_DIV_MEAN: begin
                    if (div_stat.done) begin
                        r_target <= div_quo[GAIN_W-1:0];
                    end
                end
                S_SET: begin
                    // Work out direction and number of pot steps to the target.
                    if (r_target > r_gain) begin
                        r_step_up <= 1'b1;
                        r_steps   <= STEPS_W'(r_target - r_gain);
                    end else begin
                        r_step_up <= 1'b0;
                        r_steps   <= STEPS_W'(r_gain - r_target);
                    end
                    if (r_target != r_gain) begin
                        r_phase   <= PH_STEP;
                        r_pulse_t <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // The quotient register takes either the divider result or, for a zero
    // span, the saturated value.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SPAN && sp_zero) begin
            r_quot <= DIV_W'(r_gain_max);
        end else if (r_state == S_DIV_GAIN && div_stat.done) begin
            r_quot <= div_quo;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (ld_out) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_m_tdata <= {
                {(OUT_DATA_W - 4 - 2*GAIN_W - SPAN_W){1'b0}},
                (r_phase != PH_IDLE),
                r_eval,
                r_span,
                r_target,
                r_gain,
                r_step_up,
                r_inc
            };
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `PPGC_ASSERT_NXT(a_acc_to_tick, in_acc, r_state == S_TICK, "accepted item did not start a tick")
    `PPGC_ASSERT_IMP(a_div_free, div_start, !div_stat.busy, "divider started while busy")
    `PPGC_ASSERT_IMP(a_step_left, r_phase == PH_STEP, r_steps != '0, "stepping with no steps left")
    `PPGC_ASSERT_IMP(a_hist_cnt, 1'b1, r_hist_cnt <= HIST_CNT_W'(WINDOW), "history count overflow")

endmodule

// ===== rtl/ppgc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// gain and mean computations. Depends on ppgc_pkg.
module ppgc_div
    import ppgc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output t_div_stat        o_stat,
    output logic [DIV_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_dvs;

    logic [DIV_W:0]       rem_sh;
    logic                 take;
    logic [DIV_W:0]       rem_sub;

    // Shift in the next dividend bit and try the subtraction.
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_W-1]};
        take    = (rem_sh >= {1'b0, r_dvs});
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], take};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the peak-to-peak gain control block.
// Depends on ppgc_pkg and the peak_to_peak_gain_control RTL only.
module tb_top;
    import ppgc_pkg::*;

    // One timer tick as it travels on the input stream.
    typedef struct {
        logic signed [SAMPLE_W-1:0] ir;
        logic signed [SAMPLE_W-1:0] red;
    } t_tick;

    // One result item, unpacked into its fields.
    typedef struct {
        bit                inc;
        bit                dir;
        logic [GAIN_W-1:0] gain;
        logic [GAIN_W-1:0] aim;
        logic [SPAN_W-1:0] span;
        bit                eval;
        bit                busy;
    } t_gain_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    peak_to_peak_gain_control dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Ticks waiting to be sent; the head is the item currently offered.
    t_tick        tick_q[$];
    // Results the gain loop should produce, oldest first.
    t_gain_report gain_report_q[$];
    int           mismatch_cnt = 0;

    // Idling control. The calm flags switch off the random gaps on one side,
    // and the stall request starts one long hold-off of the receiver.
    bit src_calm = 1'b0;
    bit sink_calm = 1'b0;
    bit stall_req = 1'b0;
    bit rx_blocked = 1'b0;
    int src_gap;
    int sink_gap;

    // Mirror of the configuration registers.
    int cfg_num, cfg_settle, cfg_hold, cfg_gmax, cfg_gmin, cfg_hi, cfg_lo, cfg_boot;

    // Mirror of the gain loop state.
    logic signed [SAMPLE_W-1:0] ir_top, ir_bottom, red_top, red_bottom;
    int                         settle_cnt, hold_cnt;
    logic [GAIN_W-1:0]          gain_hist [WINDOW];
    int                         fill_cnt;
    int                         pot_gain, aim_gain;
    t_phase                     loop_phase;
    int                         pulse_pos, steps_cnt;
    bit                         going_up;
    int                         span_seen;

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // One tick of a potentiometer pulse. Returns the level of the increment
    // pin and flags the tick that completes the pulse. Starting a pulse
    // restarts the settle count.
    function automatic bit pot_pulse(output bit finished);
        bit lvl;
        if (pulse_pos == 0) settle_cnt = 0;
        lvl = (pulse_pos < cfg_hi);
        pulse_pos++;
        finished = 1'b0;
        if (pulse_pos >= cfg_hi + cfg_lo) begin
            pulse_pos = 0;
            finished = 1'b1;
        end
        return lvl;
    endfunction

    // Advances the mirrored gain loop by one tick and queues the result
    // that the block must report for it.
    function automatic void step_gain_loop(input t_tick t);
        t_gain_report r;
        bit           done;
        int           s_ir, s_red, s, q, sum, i;
        r.inc  = 1'b0;
        r.eval = 1'b0;
        if (settle_cnt < 'hFFFF) settle_cnt++;
        if (hold_cnt < 'hFFFF) hold_cnt++;

        // The start-up count is compared with the live register value.
        if (loop_phase == PH_STARTUP && steps_cnt >= cfg_boot) begin
            loop_phase = PH_IDLE;
            steps_cnt  = 0;
            pot_gain   = 1;
        end

        if (loop_phase == PH_STARTUP) begin
            going_up = 1'b0;
            r.inc = pot_pulse(done);
            if (done) steps_cnt = (steps_cnt + 1) & 'hFF;
        end else if (loop_phase == PH_STEP) begin
            r.inc = pot_pulse(done);
            if (done) begin
                if (going_up) begin
                    if (pot_gain < GAIN_MAXVAL) pot_gain++;
                end else if (pot_gain > 0) begin
                    pot_gain--;
                end
                if (steps_cnt > 0) steps_cnt--;
                if (steps_cnt == 0) loop_phase = PH_IDLE;
            end
        end else if (settle_cnt > cfg_settle) begin
            // Any new extreme on either channel restarts the hold count.
            if (t.ir < ir_bottom) begin
                ir_bottom = t.ir;
                hold_cnt = 0;
            end
            if (t.red < red_bottom) begin
                red_bottom = t.red;
                hold_cnt = 0;
            end
            if (t.ir > ir_top) begin
                ir_top = t.ir;
                hold_cnt = 0;
            end
            if (t.red > red_top) begin
                red_top = t.red;
                hold_cnt = 0;
            end
            if (hold_cnt >= cfg_hold) begin
                // Evaluation: larger span, quotient, clamps (the lower one
                // last so that it wins), then the history mean as target.
                s_red = int'(red_top) - int'(red_bottom);
                s_ir  = int'(ir_top) - int'(ir_bottom);
                s = (s_red > s_ir) ? s_red : s_ir;
                if (s < 0) s = 0;
                span_seen = s & 'h7FF;
                q = (span_seen == 0) ? cfg_gmax : cfg_num / span_seen;
                if (q >= cfg_gmax) q = cfg_gmax;
                if (q <= cfg_gmin) q = cfg_gmin;
                if (fill_cnt < WINDOW) fill_cnt++;
                sum = 0;
                for (i = 0; i < WINDOW - 1; i++) begin
                    gain_hist[i] = gain_hist[i + 1];
                    sum += int'(gain_hist[i]);
                end
                gain_hist[WINDOW - 1] = q[GAIN_W-1:0];
                sum += int'(gain_hist[WINDOW - 1]);
                aim_gain = (sum / fill_cnt) & 'h7F;
                if (aim_gain > pot_gain) begin
                    going_up  = 1'b1;
                    steps_cnt = aim_gain - pot_gain;
                end else begin
                    // An equal target leaves the direction pin low.
                    going_up  = 1'b0;
                    steps_cnt = pot_gain - aim_gain;
                end
                if (steps_cnt > 0) begin
                    loop_phase = PH_STEP;
                    pulse_pos  = 0;
                end
                // The extremes restart but the hold count is left running.
                ir_top = EXT_HIGH_RST;
                red_top = EXT_HIGH_RST;
                ir_bottom = EXT_LOW_RST;
                red_bottom = EXT_LOW_RST;
                r.eval = 1'b1;
            end
        end

        r.dir  = going_up;
        r.gain = pot_gain[GAIN_W-1:0];
        r.aim  = aim_gain[GAIN_W-1:0];
        r.span = span_seen[SPAN_W-1:0];
        r.busy = (loop_phase != PH_IDLE);
        gain_report_q.push_back(r);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_cnt++;
        end
    endfunction

    function automatic void check_report(input logic [OUT_DATA_W-1:0] d);
        t_gain_report e;
        if (gain_report_q.size() == 0) begin
            $display("%0t ns: result item %h with none expected, expected nothing, actual %h",
                     $time, d, d);
            mismatch_cnt++;
            return;
        end
        e = gain_report_q.pop_front();
        check_field("inc_pin", int'(e.inc), int'(d[0]));
        check_field("updown_pin", int'(e.dir), int'(d[1]));
        check_field("gain_now", int'(e.gain), int'(d[8:2]));
        check_field("gain_target", int'(e.aim), int'(d[15:9]));
        check_field("span", int'(e.span), int'(d[26:16]));
        check_field("evaluated", int'(e.eval), int'(d[27]));
        check_field("busy_res", int'(e.busy), int'(d[28]));
    endfunction

    // Sender. The head of tick_q is offered until it is taken; the mirror is
    // advanced at the edge where the item is accepted. The mirror is also
    // cleared here while reset is held.
    always @(posedge i_clk) begin : tick_sender
        bit vld;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            src_gap = 0;
            cfg_num = int'(GAIN_NUM_RST);
            cfg_settle = int'(SETTLE_RST);
            cfg_hold = int'(HOLD_RST);
            cfg_gmax = int'(GAIN_MAX_RST);
            cfg_gmin = int'(GAIN_MIN_RST);
            cfg_hi = int'(PULSE_HI_RST);
            cfg_lo = int'(PULSE_LO_RST);
            cfg_boot = int'(STARTUP_RST);
            ir_top = EXT_HIGH_RST;
            red_top = EXT_HIGH_RST;
            ir_bottom = EXT_LOW_RST;
            red_bottom = EXT_LOW_RST;
            settle_cnt = 0;
            hold_cnt = 0;
            foreach (gain_hist[i]) gain_hist[i] = '0;
            fill_cnt = 0;
            pot_gain = 1;
            aim_gain = 0;
            loop_phase = PH_STARTUP;
            pulse_pos = 0;
            steps_cnt = 0;
            going_up = 1'b0;
            span_seen = 0;
        end else begin
            vld = i_s_tvalid;
            if (i_s_tvalid && o_s_tready) begin
                step_gain_loop(tick_q.pop_front());
                vld = 1'b0;
                src_gap = idle_len(src_calm);
            end
            if (!vld) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (tick_q.size() > 0) begin
                    vld = 1'b1;
                    i_s_tdata <= {{(IN_DATA_W - 2 * SAMPLE_W){1'b0}}, tick_q[0].red, tick_q[0].ir};
                end
            end
            i_s_tvalid <= vld;
        end
    end

    // Receiver. Results are checked at the edge where they are taken; ready
    // then drops for a random gap, or for as long as the long stall lasts.
    always @(posedge i_clk) begin : report_sink
        bit rdy;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                check_report(o_m_tdata);
                sink_gap = idle_len(sink_calm);
            end
            if (rx_blocked) begin
                rdy = 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            i_m_tready <= rdy;
        end
    end

    // The one long hold-off of the receiver. The block fills its result register, takes
    // one more tick, then waits in its emit state and refuses ticks while the sender offers.
    initial begin : rx_stall
        wait (stall_req);
        @(posedge i_clk);
        rx_blocked <= 1'b1;
        repeat (300) @(posedge i_clk);
        rx_blocked <= 1'b0;
    end

    initial begin : watchdog
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // One register write, mirrored into the predictor at the same time.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_GAIN_NUM: cfg_num = int'(val);
            CFG_SETTLE:   cfg_settle = int'(val);
            CFG_HOLD:     cfg_hold = int'(val);
            CFG_GAIN_MAX: cfg_gmax = int'(val[GAIN_W-1:0]);
            CFG_GAIN_MIN: cfg_gmin = int'(val[GAIN_W-1:0]);
            CFG_PULSE_HI: cfg_hi = int'(val[7:0]);
            CFG_PULSE_LO: cfg_lo = int'(val[7:0]);
            CFG_STARTUP:  cfg_boot = int'(val[7:0]);
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_settings(input int num, input int settle, input int hold,
                                 input int gmax, input int gmin, input int hi,
                                 input int lo, input int boot);
        write_reg(CFG_GAIN_NUM, CFG_DATA_W'(num));
        write_reg(CFG_SETTLE, CFG_DATA_W'(settle));
        write_reg(CFG_HOLD, CFG_DATA_W'(hold));
        write_reg(CFG_GAIN_MAX, CFG_DATA_W'(gmax));
        write_reg(CFG_GAIN_MIN, CFG_DATA_W'(gmin));
        write_reg(CFG_PULSE_HI, CFG_DATA_W'(hi));
        write_reg(CFG_PULSE_LO, CFG_DATA_W'(lo));
        write_reg(CFG_STARTUP, CFG_DATA_W'(boot));
    endtask

    // Picks a register value, now and then one of its extremes.
    function automatic int pick_reg(input int lo, input int hi, input int elo, input int ehi);
        case ($urandom_range(0, 11))
            0: return elo;
            1: return ehi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // The sender is idle once every tick has gone and every result has come.
    task automatic wait_drained;
        while (tick_q.size() != 0 || gain_report_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic push_tick(input int ir, input int red);
        t_tick t;
        t.ir = SAMPLE_W'(ir);
        t.red = SAMPLE_W'(red);
        tick_q.push_back(t);
    endtask

    // Random ticks, mostly in bursts of a repeating waveform so that the
    // extremes stop growing and the hold count can run out. The rest are
    // raw 11-bit values, which also bring in -1024.
    task automatic queue_ticks(input int count);
        t_tick pattern[8];
        int    period, burst, pos, ci, cr, ai, ar, k, p;
        burst = 0;
        period = 1;
        pos = 0;
        for (k = 0; k < count; k++) begin
            if (burst == 0) begin
                burst = $urandom_range(12, 60);
                period = $urandom_range(1, 8);
                pos = 0;
                ci = $urandom_range(0, 1800) - 900;
                cr = $urandom_range(0, 1800) - 900;
                ai = $urandom_range(0, 1023 - ((ci < 0) ? -ci : ci));
                ar = $urandom_range(0, 1023 - ((cr < 0) ? -cr : cr));
                for (p = 0; p < period; p++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        pattern[p].ir = SAMPLE_W'($urandom);
                        pattern[p].red = SAMPLE_W'($urandom);
                    end else begin
                        pattern[p].ir = SAMPLE_W'(ci + $urandom_range(0, 2 * ai) - ai);
                        pattern[p].red = SAMPLE_W'(cr + $urandom_range(0, 2 * ar) - ar);
                    end
                end
            end
            burst--;
            if ($urandom_range(0, 9) == 0) begin
                push_tick($urandom, $urandom);
            end else begin
                tick_q.push_back(pattern[pos]);
                pos = (pos + 1) % period;
            end
        end
    endtask

    initial begin : stimulus
        int ph;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Short start-up of three down pulses, each one tick high and one tick low, immediate
        // tracking and a one-tick hold.
        load_settings(400, 0, 1, 6, 1, 1, 1, 3);
        @(negedge i_clk);
        push_tick(0, 0);
        push_tick(0, 0);
        wait_drained();

        // One pulse has completed; lowering the start-up count to one ends
        // start-up on the next tick.
        write_reg(CFG_STARTUP, CFG_DATA_W'(1));
        @(negedge i_clk);
        // Full-scale extremes on both channels, -1024 included. The span
        // reaches 2047, the quotient clamps to the minimum and the target
        // equals the current gain, so no pulses follow.
        push_tick(-1024, 0);
        push_tick(1023, -1024);
        push_tick(0, 1023);
        push_tick(0, 1023);
        // A flat input gives a zero span, which saturates to the maximum and
        // starts stepping up.
        push_tick(5, 5);
        push_tick(5, 5);
        repeat (4) push_tick(0, 0);
        wait_drained();

        // Minimum above maximum: the minimum wins.
        load_settings(400, 0, 1, 4, 9, 1, 1, 3);
        @(negedge i_clk);
        push_tick(100, -100);
        push_tick(-100, 100);
        push_tick(-100, 100);
        repeat (4) push_tick(0, 0);
        wait_drained();

        // Zero clamp: a quotient of zero with no lower bound enters history.
        load_settings(1, 0, 1, 127, 0, 1, 1, 3);
        @(negedge i_clk);
        push_tick(100, -100);
        push_tick(-100, 100);
        push_tick(-100, 100);
        repeat (2) push_tick(0, 0);
        wait_drained();

        // Upper extremes of every register; a saturated settle stops tracking.
        load_settings(65535, 65535, 65535, 127, 127, 255, 255, 255);
        @(negedge i_clk);
        queue_ticks(20);
        wait_drained();

        // Long receiver stall against a sender that never pauses.
        load_settings(300, 2, 3, 20, 1, 2, 1, 0);
        @(negedge i_clk);
        src_calm = 1'b1;
        sink_calm = 1'b1;
        stall_req = 1'b1;
        queue_ticks(40);
        wait_drained();

        // Random settings, each phase started only once the block has drained.
        for (ph = 0; ph < 10; ph++) begin
            load_settings(pick_reg(16, 4000, 1, 65535), pick_reg(0, 30, 0, 65535),
                          pick_reg(1, 12, 1, 65535), pick_reg(2, 60, 1, 127),
                          pick_reg(1, 12, 1, 127), pick_reg(1, 4, 1, 255),
                          pick_reg(1, 4, 1, 255), pick_reg(0, 255, 0, 255));
            @(negedge i_clk);
            src_calm = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            queue_ticks(110);
            wait_drained();
        end

        // Allow for any stray result before the verdict.
        repeat (60) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
